// ----- src/pgbr_pkg.sv -----
// Shared types and constants for the pulse-gap bus receiver.
package pgbr_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes, taken from csr address bits [3:2].
   localparam logic [1:0] REG_ZERO_GAP_LIMIT = 2'd0;
   localparam logic [1:0] REG_FRAME_GAP      = 2'd1;
   localparam logic [1:0] REG_MAX_BYTES      = 2'd2;

   localparam logic [7:0] ZERO_GAP_LIMIT_RESET = 8'd4;
   localparam logic [7:0] FRAME_GAP_RESET      = 8'd16;
   localparam logic [7:0] MAX_BYTES_RESET      = 8'd30;

   localparam logic [2:0] LAST_BIT_POSITION = 3'd7;

   typedef enum logic [1:0] {
      EVENT_BYTE     = 2'd0,
      EVENT_COMPLETE = 2'd1,
      EVENT_ERROR    = 2'd2,
      EVENT_OVERRUN  = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [7:0] zero_gap_limit;
      logic [7:0] frame_gap;
      logic [7:0] max_bytes;
   } config_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [7:0]     byte_value;
      logic [7:0]     byte_count;
   } result_type;

endpackage

// ----- src/pgbr_csr.sv -----
// Configuration register file with an APB-style access port.
module pgbr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pgbr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [pgbr_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [pgbr_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready,
   output pgbr_pkg::config_type                 cfg
);
   import pgbr_pkg::*;

   config_type  cfg_ff;
   config_type  cfg_in;
   logic        write_en;
   logic [1:0]  reg_index;
   logic [7:0]  read_value;

   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_ZERO_GAP_LIMIT: cfg_in.zero_gap_limit = pwdata[7:0];
            REG_FRAME_GAP:      cfg_in.frame_gap      = pwdata[7:0];
            REG_MAX_BYTES:      cfg_in.max_bytes      = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ZERO_GAP_LIMIT: read_value = cfg_ff.zero_gap_limit;
         REG_FRAME_GAP:      read_value = cfg_ff.frame_gap;
         REG_MAX_BYTES:      read_value = cfg_ff.max_bytes;
         default:            read_value = 8'd0;
      endcase
   end

   assign prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, read_value};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_gap_limit <= ZERO_GAP_LIMIT_RESET;
         cfg_ff.frame_gap      <= FRAME_GAP_RESET;
         cfg_ff.max_bytes      <= MAX_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/pgbr_decode.sv -----
// Gap counter, bit decoder and byte/frame tracking for one sample per step.
module pgbr_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 sample,
   input  pgbr_pkg::config_type cfg,
   output pgbr_pkg::result_type result
);
   import pgbr_pkg::*;

   logic [7:0] gap_ff,      gap_in;
   logic [2:0] bit_pos_ff,  bit_pos_in;
   logic [7:0] acc_ff,      acc_in;
   logic [7:0] length_ff,   length_in;
   logic       in_frame_ff, in_frame_in;

   logic [7:0] gap_plus;
   logic [7:0] acc_with_bit;
   logic       bit_value;

   assign gap_plus     = gap_ff + 8'd1;
   assign bit_value    = gap_ff >= cfg.zero_gap_limit;
   assign acc_with_bit = acc_ff | ({7'd0, bit_value} << bit_pos_ff);

   always_comb begin
      gap_in      = gap_ff;
      bit_pos_in  = bit_pos_ff;
      acc_in      = acc_ff;
      length_in   = length_ff;
      in_frame_in = in_frame_ff;
      result      = '0;
      result.kind = EVENT_BYTE;

      if (step_en) begin
         if (sample) begin
            // Recessive: extend the run, clamped at the frame gap.
            if (gap_ff < cfg.frame_gap) begin
               gap_in = gap_plus;
               if (gap_plus == cfg.frame_gap && in_frame_ff) begin
                  result.valid      = 1'b1;
                  result.kind       = (bit_pos_ff != 3'd0) ? EVENT_ERROR : EVENT_COMPLETE;
                  result.byte_count = length_ff;
                  bit_pos_in        = 3'd0;
                  acc_in            = 8'd0;
                  length_in         = 8'd0;
                  in_frame_in       = 1'b0;
               end
            end else begin
               gap_in = cfg.frame_gap;
            end
         end else if (gap_ff != 8'd0) begin
            gap_in = 8'd0;
            if (gap_ff >= cfg.frame_gap && gap_ff >= cfg.zero_gap_limit) begin
               // A long run opens a new frame and carries no bit.
               bit_pos_in  = 3'd0;
               acc_in      = 8'd0;
               length_in   = 8'd0;
               in_frame_in = 1'b1;
            end else if (in_frame_ff) begin
               if (bit_pos_ff != LAST_BIT_POSITION) begin
                  acc_in     = acc_with_bit;
                  bit_pos_in = bit_pos_ff + 3'd1;
               end else begin
                  result.valid      = 1'b1;
                  result.byte_count = length_ff;
                  bit_pos_in        = 3'd0;
                  acc_in            = 8'd0;
                  if (length_ff >= cfg.max_bytes) begin
                     result.kind = EVENT_OVERRUN;
                     length_in   = 8'd0;
                  end else begin
                     result.kind       = EVENT_BYTE;
                     result.byte_value = acc_with_bit;
                     length_in         = length_ff + 8'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= 8'd0;
         bit_pos_ff  <= 3'd0;
         acc_ff      <= 8'd0;
         length_ff   <= 8'd0;
         in_frame_ff <= 1'b0;
      end else begin
         gap_ff      <= gap_in;
         bit_pos_ff  <= bit_pos_in;
         acc_ff      <= acc_in;
         length_ff   <= length_in;
         in_frame_ff <= in_frame_in;
      end
   end

   // Partial bytes only exist inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      (bit_pos_ff != 3'd0) |-> in_frame_ff)
      else $error("bit position advanced outside a frame");

   // The accumulator is cleared whenever a byte slot restarts.
   assert property (@(posedge clock) disable iff (reset)
      (bit_pos_ff == 3'd0) |-> (acc_ff == 8'd0))
      else $error("stale accumulator bits at byte start");

   // Counted bytes only exist inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      (length_ff != 8'd0) |-> in_frame_ff)
      else $error("frame length held outside a frame");

   // State moves only when a sample is processed.
   assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(gap_ff) && $stable(in_frame_ff) && $stable(length_ff))
      else $error("decoder state changed without a sample");

endmodule

// ----- src/pulse_gap_bus_receiver_top.sv -----
// Top level of the pulse-gap bus receiver: sample register, decoder, result register.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     req_line_sample
//   rsp       out        rsp_valid / rsp_ready     rsp_event_kind, rsp_byte_value,
//                                                   rsp_byte_count
//   csr       in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// One sample item is accepted per cycle while the result side keeps up. An accepted item
// is held in the sample register, is decoded against the running state, and any result
// lands in the result register, from which it is offered. Reset is synchronous and
// active high; it empties both registers, clears the decoder state and loads the register
// defaults. While a result waits unread, the held sample cannot be decoded: an empty
// sample register still takes one item, and further items stall until the result is taken.
module pulse_gap_bus_receiver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_line_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_event_kind,
   output logic [7:0]                           rsp_byte_value,
   output logic [7:0]                           rsp_byte_count,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pgbr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [pgbr_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [pgbr_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);
   import pgbr_pkg::*;

   config_type cfg;
   result_type result;

   // Sample register.
   logic in_valid_ff,  in_valid_in;
   logic in_sample_ff, in_sample_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff,      kind_in;
   logic [7:0] value_ff,     value_in;
   logic [7:0] count_ff,     count_in;

   logic advance;
   logic step_en;
   logic req_fire;

   // The held sample may be decoded whenever the result register is free or
   // is being emptied this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   pgbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pgbr_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_fire) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_line_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      if (step_en) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            kind_in  = result.kind;
            value_in = result.byte_value;
            count_in = result.byte_count;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      count_ff     <= count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_byte_value = value_ff;
   assign rsp_byte_count = count_ff;

   // A decoded result never lands on top of one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && result.valid) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   // A held sample that cannot be decoded stays in place.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_sample_ff))
      else $error("stalled sample lost");

   // Only byte events carry a nonzero byte value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != EVENT_BYTE) |-> (value_ff == 8'd0))
      else $error("byte value set on a frame event");

endmodule

// ----- bench/pulse_gap_bus_receiver_top_tb.sv -----
// Self-checking testbench for the pulse-gap bus receiver: directed rows, then random frames.
module pulse_gap_bus_receiver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pgbr_pkg::*;

   // The run stops feeding new register settings once this many samples have gone in.
   localparam int ITEM_TARGET = 1750;
   // Cycles with no item moving on any port before the run is declared hung.
   localparam int STALL_LIMIT = 3000;
   // Idle cycles after the last owed event, so a sample that gave no event leaves the pipe.
   localparam int SETTLE_CYCLES = 4;
   // Length of the deliberate result-side hold-off.
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 150;

   // One decoded bus event as the result channel carries it.
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     value;
      logic [7:0]     count;
   } bus_event_type;

   // One row of the directed part. A row either writes all three registers or drives one
   // sample; a pinned row carries its expected outcome typed in by hand.
   typedef struct packed {
      logic           is_config;
      logic           sample;
      config_type     regs;
      logic           pinned;
      logic           pin_has;
      event_kind_type pin_kind;
      logic [7:0]     pin_count;
   } sample_row_type;

   localparam config_type NO_REGS = '0;
   // Shortest legal runs: every run of one is a 1 bit, a run of two starts or ends a frame,
   // and with no bytes allowed the first full byte turns into an overrun.
   localparam config_type SHORTEST_NO_BYTES = '{8'd1, 8'd2, 8'd0};
   // Lowers the frame gap below the saturated run count left by the rows before it.
   localparam config_type GAP_LOWERED = '{8'd1, 8'd1, 8'd0};

   localparam int DIRECTED_ROWS = 30;
   localparam int FIXED_PHASES = 8;
   // The first fixed phase holds the result side off; the second runs with no idling at all.
   localparam int HOLD_PHASE = 0;
   localparam int STEADY_PHASE = 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_line_sample = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [7:0] rsp_byte_value;
   logic [7:0] rsp_byte_count;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   // Register copies held by the bench, updated at the edge at which each write lands.
   logic [7:0] zero_limit_reg = ZERO_GAP_LIMIT_RESET;
   logic [7:0] frame_gap_reg = FRAME_GAP_RESET;
   logic [7:0] max_bytes_reg = MAX_BYTES_RESET;

   // Decoder state of the bench's own model of the receiver, all clear after reset.
   logic [7:0] run_len = '0;
   logic [2:0] bit_slot = '0;
   logic [7:0] byte_acc = '0;
   logic [7:0] frame_bytes = '0;
   logic       framing = 1'b0;

   // Events the receiver still owes, oldest first.
   bus_event_type pending_events [$];
   // Line samples queued up for the current register setting.
   logic       line_plan [$];
   config_type phase_cfg;

   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stalled_cycles = 0;
   int mismatches = 0;
   int items_sent = 0;
   int events_checked = 0;
   int settings_used = 0;
   int kinds_seen [4] = '{0, 0, 0, 0};

   // Directed rows. Straight out of reset a dominant sample with no run before it does
   // nothing, and a short run before any frame start decodes a bit that is dropped. Under
   // the shortest settings a frame is opened, a byte of all ones overflows the empty byte
   // budget, and a single pending bit followed by a frame gap ends the frame in error.
   // Finally the frame gap is lowered under the saturated run, so the next recessive
   // sample only clamps the count, and the dominant sample after it opens a new frame.
   sample_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 1'b0, NO_REGS, 1'b1, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b1, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b1, 1'b0, SHORTEST_NO_BYTES, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b1, 1'b1, EVENT_OVERRUN, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b1, 1'b1, EVENT_ERROR, 8'd0},
      '{1'b1, 1'b0, GAP_LOWERED, 1'b0, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b1, NO_REGS, 1'b1, 1'b0, EVENT_BYTE, 8'd0},
      '{1'b0, 1'b0, NO_REGS, 1'b0, 1'b0, EVENT_BYTE, 8'd0}
   };

   // Register settings visited after the directed rows: a busy small setting used for the
   // hold-off, one run without idling, the shortest runs with no byte budget, all zeros,
   // a one-sample frame gap, all maximums, a zero limit above the frame gap, and the reset
   // values. Random small settings follow until enough samples have gone in.
   config_type fixed_cfgs [FIXED_PHASES] = '{
      '{8'd2, 8'd5, 8'd3},
      '{8'd3, 8'd7, 8'd2},
      '{8'd1, 8'd2, 8'd0},
      '{8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd1, 8'd0},
      '{8'd255, 8'd255, 8'd255},
      '{8'd9, 8'd5, 8'd1},
      '{ZERO_GAP_LIMIT_RESET, FRAME_GAP_RESET, MAX_BYTES_RESET}
   };

   pulse_gap_bus_receiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_line_sample (req_line_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_byte_count  (rsp_byte_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #2 clock = ~clock;

   // Decodes one accepted line sample against the bench's copy of the receiver state and
   // says whether it yields a bus event. Recessive samples lengthen the run, which
   // saturates at the frame gap and closes an open frame on reaching it. A dominant sample
   // decodes the run as a 0 bit, a 1 bit or a frame start; bits outside a frame are lost.
   task automatic decode_sample(input logic sample, output bit produced,
                                output bus_event_type ev);
      logic [7:0] gap;
      logic       bit_value;
      produced = 1'b0;
      ev = '0;
      if (sample) begin
         if (run_len < frame_gap_reg) begin
            run_len = run_len + 8'd1;
            if (run_len == frame_gap_reg && framing) begin
               ev.kind = (bit_slot != 3'd0) ? EVENT_ERROR : EVENT_COMPLETE;
               ev.count = frame_bytes;
               produced = 1'b1;
               bit_slot = '0;
               byte_acc = '0;
               frame_bytes = '0;
               framing = 1'b0;
            end
         end else begin
            // A frame gap lowered under the current run only clamps the count.
            run_len = frame_gap_reg;
         end
      end else if (run_len != 8'd0) begin
         gap = run_len;
         run_len = '0;
         if (gap >= zero_limit_reg && gap >= frame_gap_reg) begin
            bit_slot = '0;
            byte_acc = '0;
            frame_bytes = '0;
            framing = 1'b1;
         end else if (framing) begin
            bit_value = (gap >= zero_limit_reg);
            byte_acc = byte_acc | (8'(bit_value) << bit_slot);
            if (bit_slot != LAST_BIT_POSITION) begin
               bit_slot = bit_slot + 3'd1;
            end else if (frame_bytes >= max_bytes_reg) begin
               ev.kind = EVENT_OVERRUN;
               ev.count = frame_bytes;
               produced = 1'b1;
               bit_slot = '0;
               byte_acc = '0;
               frame_bytes = '0;
            end else begin
               ev.kind = EVENT_BYTE;
               ev.value = byte_acc;
               ev.count = frame_bytes;
               produced = 1'b1;
               frame_bytes = frame_bytes + 8'd1;
               bit_slot = '0;
               byte_acc = '0;
            end
         end
      end
   endtask

   // Offers one sample, with random idle cycles ahead of it, and holds it until the
   // receiver takes it. The event it should cause is queued at the accepting edge.
   task automatic send_line(input logic sample, input bit pinned, input bit pin_has,
                            input bus_event_type pin_ev);
      bit            produced;
      bus_event_type ev;
      while (gaps_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_sample <= sample;
      do @(posedge clock); while (!req_ready);
      decode_sample(sample, produced, ev);
      if (pinned) begin
         produced = pin_has;
         ev = pin_ev;
      end
      if (produced) begin
         pending_events.push_back(ev);
      end
      items_sent++;
   endtask

   // Stops offering samples, waits for every owed event, then lets the pipe empty so a
   // sample that gives no event is not decoded under the next register setting.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the three registers back to back; each write lands at the edge at which the
   // access phase completes, and the bench's copy changes at that same edge.
   task automatic program_regs(input config_type cfg);
      logic [1:0] reg_index [3];
      logic [7:0] reg_value [3];
      int         i;
      reg_index = '{REG_ZERO_GAP_LIMIT, REG_FRAME_GAP, REG_MAX_BYTES};
      reg_value = '{cfg.zero_gap_limit, cfg.frame_gap, cfg.max_bytes};
      for (i = 0; i < 3; i++) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {reg_index[i], 2'b00};
         pwdata <= CSR_DATA_WIDTH'(reg_value[i]);
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         case (reg_index[i])
            REG_ZERO_GAP_LIMIT: zero_limit_reg = reg_value[i];
            REG_FRAME_GAP:      frame_gap_reg = reg_value[i];
            REG_MAX_BYTES:      max_bytes_reg = reg_value[i];
            default:            ;
         endcase
         if (i == 2) begin
            psel <= 1'b0;
            penable <= 1'b0;
         end
      end
      settings_used++;
   endtask

   // Queues a recessive run of the given length closed by a dominant sample.
   task automatic plan_run(input int len);
      repeat (len) line_plan.push_back(1'b1);
      line_plan.push_back(1'b0);
   endtask

   // Queues a run that decodes as the given bit under the current setting. Run lengths
   // favor the short end, with the edges of each band picked now and then. When the
   // setting leaves no run for that bit the other bit is sent instead.
   task automatic plan_bit(input logic bit_value);
      int lo0, hi0, lo1, hi1, lo, hi, len;
      lo0 = 1;
      hi0 = ((phase_cfg.zero_gap_limit < phase_cfg.frame_gap) ?
             int'(phase_cfg.zero_gap_limit) : int'(phase_cfg.frame_gap)) - 1;
      lo1 = (phase_cfg.zero_gap_limit > 8'd0) ? int'(phase_cfg.zero_gap_limit) : 1;
      hi1 = int'(phase_cfg.frame_gap) - 1;
      if (bit_value ? (hi1 >= lo1) : (hi0 >= lo0)) begin
         lo = bit_value ? lo1 : lo0;
         hi = bit_value ? hi1 : hi0;
      end else if (hi1 >= lo1) begin
         lo = lo1;
         hi = hi1;
      end else if (hi0 >= lo0) begin
         lo = lo0;
         hi = hi0;
      end else begin
         lo = 1;
         hi = 1;
      end
      case ($urandom_range(7))
         0:       len = lo;
         1:       len = hi;
         default: len = lo + $urandom_range((hi - lo > 3) ? 3 : hi - lo);
      endcase
      plan_run(len);
   endtask

   // Queues one frame: a start run, whole bytes of random content, and usually a closing gap. A
   // broken frame leaves a partial byte behind. With a small byte budget the frame may
   // carry one byte too many to provoke an overrun; with a long frame gap it carries one.
   task automatic plan_frame(input bit broken);
      int         nbytes, k, b;
      logic [7:0] data;
      if (phase_cfg.frame_gap > 8'd32) begin
         nbytes = 1;
      end else if (phase_cfg.max_bytes <= 8'd3) begin
         nbytes = $urandom_range(int'(phase_cfg.max_bytes) + 1);
      end else begin
         nbytes = $urandom_range(3);
      end
      plan_run(int'(phase_cfg.frame_gap) + $urandom_range(1, 2));
      for (k = 0; k < nbytes; k++) begin
         case ($urandom_range(3))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = 8'($urandom);
         endcase
         for (b = 0; b < 8; b++) plan_bit(data[b]);
      end
      if (broken) begin
         repeat ($urandom_range(1, 7)) plan_bit(1'($urandom));
      end
      // Without a closing gap the next start run ends the frame instead.
      if (broken || $urandom_range(3) != 0) begin
         repeat (int'(phase_cfg.frame_gap)) line_plan.push_back(1'b1);
      end
   endtask

   // Fills the plan for one register setting: mostly well-formed frames, some broken
   // ones, and bursts of line noise of random density.
   task automatic plan_phase(input int budget);
      int pick, density;
      while (line_plan.size() < budget) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            plan_frame(1'b0);
         end else if (pick < 87) begin
            plan_frame(1'b1);
         end else begin
            density = $urandom_range(100);
            repeat ($urandom_range(1, 12)) line_plan.push_back($urandom_range(99) < density);
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input bus_event_type want,
                                input bus_event_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch at %0t: %s: expected kind %0d byte %02h count %0d,",
                  $time, what, want.kind, want.value, want.count);
         $display("   got kind %0d byte %02h count %0d",
                  seen.kind, seen.value, seen.count);
      end
   endtask

   // The result side takes items at random, or always while idling is off, except for one
   // long hold-off that the main sequence asks for. Samples keep coming meanwhile, so the
   // receiver fills up and its input stalls.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 18);
      end
   end

   // Every event taken from the receiver is checked against the oldest one owed.
   always @(posedge clock) begin : event_check
      bus_event_type seen;
      bus_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind = event_kind_type'(rsp_event_kind);
         seen.value = rsp_byte_value;
         seen.count = rsp_byte_count;
         events_checked++;
         kinds_seen[rsp_event_kind]++;
         if (pending_events.size() == 0) begin
            flag_mismatch("event with none owed", '0, seen);
         end else begin
            want = pending_events.pop_front();
            if (seen.kind !== want.kind || seen.value !== want.value ||
                seen.count !== want.count) begin
               flag_mismatch("event fields differ", want, seen);
            end
         end
      end
   end

   // A hung receiver shows up as a long run of cycles in which no item moves anywhere.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d events still owed.",
                     STALL_LIMIT, pending_events.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Main sequence: reset, the directed rows, then one register setting after another,
   // each followed by a plan of random frames, and finally the drain and the verdict.
   initial begin
      sample_row_type row;
      bus_event_type  pin_ev;
      int             phase;
      int             budget;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_config) begin
            drain_and_settle();
            program_regs(row.regs);
         end else begin
            pin_ev.kind = row.pin_kind;
            pin_ev.value = 8'd0;
            pin_ev.count = row.pin_count;
            send_line(row.sample, row.pinned, row.pin_has, pin_ev);
         end
      end

      phase = 0;
      while (phase < FIXED_PHASES || items_sent < ITEM_TARGET) begin
         if (phase < FIXED_PHASES) begin
            phase_cfg = fixed_cfgs[phase];
         end else begin
            // Random small settings, with the zero limit on either side of the frame gap.
            phase_cfg.zero_gap_limit = 8'($urandom_range(1, 8));
            phase_cfg.frame_gap = 8'($urandom_range(2, 10));
            phase_cfg.max_bytes = 8'($urandom_range(4));
         end
         drain_and_settle();
         program_regs(phase_cfg);
         gaps_on = (phase != STEADY_PHASE);
         if (phase == HOLD_PHASE) begin
            hold_request = 1'b1;
         end
         if (phase_cfg.frame_gap > 8'd32) begin
            budget = 1;
         end else if (phase_cfg.frame_gap < 8'd2) begin
            budget = 60;
         end else begin
            budget = PHASE_ITEMS;
         end
         plan_phase(budget);
         while (line_plan.size() != 0) begin
            send_line(line_plan.pop_front(), 1'b0, 1'b0, '0);
         end
         phase++;
      end

      gaps_on = 1'b1;
      drain_and_settle();
      // Let any stray event surface before the verdict.
      repeat (8) @(posedge clock);

      $display("Run covered %0d line samples under %0d register settings.",
               items_sent, settings_used);
      $display("Checked %0d events: %0d bytes, %0d complete, %0d error, %0d overrun;",
               events_checked, kinds_seen[EVENT_BYTE], kinds_seen[EVENT_COMPLETE],
               kinds_seen[EVENT_ERROR], kinds_seen[EVENT_OVERRUN]);
      $display("%0d mismatches.", mismatches);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
